[design/sha_pkg.sv]
`timescale 1ns / 1ps

package sha_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last;
  } sha_in_t;

  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;
  } sha_out_t;

  // requests to the block buffer / schedule window
  typedef struct packed {
    logic       push;
    logic [1:0] lane;
    logic [7:0] byte_val;
    logic       step;
  } sha_sreq_t;

  // requests to the working variable file
  typedef struct packed {
    logic load;
    logic rotate;
    logic step;
  } sha_rctl_t;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] INIT_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

[design/sha256_byte_stream_hasher.sv]
`timescale 1ns / 1ps

// sha-256 over a byte stream
// input channel: one word per item holding a message byte, a has_byte flag and a
//   last flag; an item with has_byte low and last high closes the message (also
//   an empty one), an item with both low is dropped
// output channel: eight words per message, digest word 0 first, word_index and
//   digest_last along with each
// block intake: a byte item is taken while in_stall is low; the 64th byte of a
//   block starts a compression (read the chaining store into the working
//   variables, 64 rounds, read-add-write back into the chaining store), during
//   which in_stall stays high
// last item: padding (marker byte, zeros, eight length bytes) goes in along with
//   one or two compressions, then each digest word is fetched and shown and held
//   for however long the receiver stalls
// reset: a pass over the eight words loads the initial hash values into the
//   chaining store, in_stall stays high meanwhile; after each digest the store
//   is reloaded as the words are read out
// a stalled output word holds its payload; in_stall stays high until the last
//   digest word has been taken
module sha256_byte_stream_hasher (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  sha_pkg::sha_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output sha_pkg::sha_out_t out_data
);

  import sha_pkg::*;

  localparam logic [3:0] ST_INIT    = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_PAD     = 4'd2;
  localparam logic [3:0] ST_LOAD    = 4'd3;
  localparam logic [3:0] ST_ROUND   = 4'd4;
  localparam logic [3:0] ST_ADD     = 4'd5;
  localparam logic [3:0] ST_OUT_RD  = 4'd6;
  localparam logic [3:0] ST_OUT_LAT = 4'd7;
  localparam logic [3:0] ST_OUT_HLD = 4'd8;

  localparam logic [1:0] PH_MARK = 2'd0;
  localparam logic [1:0] PH_ZERO = 2'd1;
  localparam logic [1:0] PH_LEN  = 2'd2;

  localparam logic [5:0] LEN_POS  = 6'd56;
  localparam logic [5:0] FILL_END = 6'd63;

  logic [3:0]  state;
  logic [3:0]  cnt;
  logic [5:0]  rc;
  logic [5:0]  fill;
  logic [63:0] message_bits;
  logic [1:0]  phase;
  logic [2:0]  len_cnt;
  logic [2:0]  word_sel;
  logic        pad_active;
  logic        final_blk;

  logic        in_accept;
  logic        out_accept;
  logic        pad_push;
  logic [7:0]  pad_byte;
  logic        push;
  logic [3:0]  cnt_m1;

  logic        mem_we;
  logic [2:0]  mem_waddr;
  logic [31:0] mem_wdata;
  logic [2:0]  mem_raddr;
  logic [31:0] mem_rdata;

  sha_sreq_t   sreq;
  sha_rctl_t   rctl;
  logic [31:0] w0;
  logic [31:0] var_a;

  assign in_stall   = (state != ST_IDLE);
  assign in_accept  = in_valid && !in_stall;
  assign out_accept = out_valid && !out_stall;
  assign cnt_m1     = cnt - 4'd1;

  // padding: marker byte, zeros up to the length field, then eight length bytes
  always_comb begin
    pad_push = 1'b0;
    pad_byte = 8'h00;
    unique case (phase)
      PH_MARK: begin
        pad_push = 1'b1;
        pad_byte = PAD_BYTE;
      end
      PH_ZERO: pad_push = (fill != LEN_POS);
      PH_LEN: begin
        pad_push = 1'b1;
        pad_byte = message_bits[63:56];
      end
      default: pad_push = 1'b0;
    endcase
  end

  assign push = (in_accept && in_data.has_byte) || (state == ST_PAD && pad_push);

  always_comb begin
    sreq.push     = push;
    sreq.lane     = fill[1:0];
    sreq.byte_val = (state == ST_IDLE) ? in_data.data_byte : pad_byte;
    sreq.step     = (state == ST_ROUND);
    rctl.load     = (state == ST_LOAD) && (cnt != 4'd0);
    rctl.rotate   = (state == ST_ADD) && (cnt != 4'd0);
    rctl.step     = (state == ST_ROUND);
  end

  // chaining store port use per phase
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = 3'd0;
    mem_wdata = 32'd0;
    mem_raddr = 3'd0;
    unique case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = cnt[2:0];
        mem_wdata = INIT_HASH[cnt[2:0]];
      end
      ST_LOAD: mem_raddr = cnt[2:0];
      ST_ADD: begin
        mem_raddr = cnt[2:0];
        mem_we    = (cnt != 4'd0);
        mem_waddr = cnt_m1[2:0];
        mem_wdata = mem_rdata + var_a;
      end
      ST_OUT_RD: begin
        // old value is read out while the initial value goes back in
        mem_raddr = word_sel;
        mem_we    = 1'b1;
        mem_waddr = word_sel;
        mem_wdata = INIT_HASH[word_sel];
      end
      default: mem_we = 1'b0;
    endcase
  end

  sha_hmem u_hmem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  sha_sched u_sched (
    .clk (clk),
    .req (sreq),
    .w0  (w0)
  );

  sha_round u_round (
    .clk       (clk),
    .ctl       (rctl),
    .load_word (mem_rdata),
    .k         (ROUND_K[rc]),
    .w         (w0),
    .var_a     (var_a)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      cnt          <= 4'd0;
      rc           <= 6'd0;
      fill         <= 6'd0;
      message_bits <= 64'd0;
      phase        <= PH_MARK;
      len_cnt      <= 3'd0;
      word_sel     <= 3'd0;
      pad_active   <= 1'b0;
      final_blk    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (push) begin
        fill <= fill + 6'd1;
      end
      unique case (state)
        ST_INIT: begin
          if (cnt == 4'd7) begin
            cnt   <= 4'd0;
            state <= ST_IDLE;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_IDLE: begin
          if (in_accept) begin
            phase <= PH_MARK;
            if (in_data.has_byte) begin
              message_bits <= message_bits + 64'd8;
            end
            if (in_data.has_byte && fill == FILL_END) begin
              pad_active <= in_data.last;
              cnt        <= 4'd0;
              state      <= ST_LOAD;
            end else if (in_data.last) begin
              pad_active <= 1'b1;
              state      <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          unique case (phase)
            PH_MARK: phase <= PH_ZERO;
            PH_ZERO: begin
              if (fill == LEN_POS) begin
                phase   <= PH_LEN;
                len_cnt <= 3'd0;
              end
            end
            PH_LEN: begin
              message_bits <= {message_bits[55:0], 8'h00};
              len_cnt      <= len_cnt + 3'd1;
              if (len_cnt == 3'd7) begin
                final_blk <= 1'b1;
              end
            end
            default: phase <= PH_MARK;
          endcase
          if (pad_push && fill == FILL_END) begin
            cnt   <= 4'd0;
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          if (cnt == 4'd8) begin
            cnt   <= 4'd0;
            rc    <= 6'd0;
            state <= ST_ROUND;
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_ROUND: begin
          rc <= rc + 6'd1;
          if (rc == 6'd63) begin
            cnt   <= 4'd0;
            state <= ST_ADD;
          end
        end
        ST_ADD: begin
          if (cnt == 4'd8) begin
            cnt <= 4'd0;
            if (final_blk) begin
              final_blk  <= 1'b0;
              pad_active <= 1'b0;
              word_sel   <= 3'd0;
              state      <= ST_OUT_RD;
            end else if (pad_active) begin
              state <= ST_PAD;
            end else begin
              state <= ST_IDLE;
            end
          end else begin
            cnt <= cnt + 4'd1;
          end
        end
        ST_OUT_RD: state <= ST_OUT_LAT;
        ST_OUT_LAT: begin
          out_valid <= 1'b1;
          state     <= ST_OUT_HLD;
        end
        ST_OUT_HLD: begin
          if (out_accept) begin
            out_valid <= 1'b0;
            word_sel  <= word_sel + 3'd1;
            if (word_sel == 3'd7) begin
              state <= ST_IDLE;
            end else begin
              state <= ST_OUT_RD;
            end
          end
        end
        default: state <= ST_INIT;
      endcase
    end
  end

  // output payload, loaded once per word and held while stalled
  always_ff @(posedge clk) begin
    if (state == ST_OUT_LAT) begin
      out_data.digest_word <= mem_rdata;
      out_data.word_index  <= word_sel;
      out_data.digest_last <= (word_sel == 3'd7);
    end
  end

endmodule

[design/sha_hmem.sv]
`timescale 1ns / 1ps

// chaining state store, one write and one registered read per cycle
module sha_hmem (
  input  logic        clk,
  input  logic        we,
  input  logic [2:0]  waddr,
  input  logic [31:0] wdata,
  input  logic [2:0]  raddr,
  output logic [31:0] rdata
);

  logic [31:0] mem [8];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/sha_sched.sv]
`timescale 1ns / 1ps

// block buffer and message schedule as one sixteen word shift line
module sha_sched (
  input  logic              clk,
  input  sha_pkg::sha_sreq_t req,
  output logic [31:0]       w0
);

  import sha_pkg::*;

  logic [31:0] win [16];
  logic [23:0] acc;
  logic [31:0] packed_word;
  logic [31:0] expand;

  assign packed_word = {acc, req.byte_val};
  assign expand = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
  assign w0 = win[0];

  always_ff @(posedge clk) begin
    if (req.push) begin
      acc <= packed_word[23:0];
      if (req.lane == 2'd3) begin
        for (int i = 0; i < 15; i++) begin
          win[i] <= win[i + 1];
        end
        win[15] <= packed_word;
      end
    end else if (req.step) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i + 1];
      end
      win[15] <= expand;
    end
  end

endmodule

[design/sha_round.sv]
`timescale 1ns / 1ps

// working variables a..h and the round function
module sha_round (
  input  logic              clk,
  input  sha_pkg::sha_rctl_t ctl,
  input  logic [31:0]       load_word,
  input  logic [31:0]       k,
  input  logic [31:0]       w,
  output logic [31:0]       var_a
);

  import sha_pkg::*;

  logic [31:0] v [8];
  logic [31:0] choose;
  logic [31:0] major;
  logic [31:0] t1;
  logic [31:0] t2;

  assign choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
  assign major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
  assign t1     = v[7] + big_sigma1(v[4]) + choose + k + w;
  assign t2     = big_sigma0(v[0]) + major;
  assign var_a  = v[0];

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      for (int i = 0; i < 7; i++) begin
        v[i] <= v[i + 1];
      end
      v[7] <= load_word;
    end else if (ctl.rotate) begin
      for (int i = 0; i < 7; i++) begin
        v[i] <= v[i + 1];
      end
      v[7] <= v[0];
    end else if (ctl.step) begin
      v[7] <= v[6];
      v[6] <= v[5];
      v[5] <= v[4];
      v[4] <= v[3] + t1;
      v[3] <= v[2];
      v[2] <= v[1];
      v[1] <= v[0];
      v[0] <= t1 + t2;
    end
  end

endmodule

[design/sha_port_chk.sv]
`timescale 1ns / 1ps

module sha_port_chk (
  input logic              clk,
  input logic              rst,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input sha_pkg::sha_out_t out_data
);

  import sha_pkg::*;

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output word changed while stalled");

  // last flag only on the final word of the digest
  a_last_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.digest_last == (out_data.word_index == 3'd7)))
    else $error("digest_last does not match word_index");

  // no input taken while a digest is being delivered
  a_no_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input open during digest output");

  // chaining store load follows reset
  a_init_stall: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> in_stall && !out_valid)
    else $error("block not held after reset");

  // words follow in order within a digest
  a_idx_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !out_data.digest_last |=>
      !out_valid ##2 out_valid &&
      out_data.word_index == $past(out_data.word_index, 3) + 3'd1)
    else $error("digest words out of order");

endmodule

bind sha256_byte_stream_hasher sha_port_chk u_port_chk (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
